// File: rtl/core/aspm_pkg.sv
// Shared types and constants for the all-substrings-present matcher.
// Used by aspm_cell, aspm_pat and all_substrings_present_matcher_top.
// No dependencies.
`default_nettype none

package aspm_pkg;

    // Field and register widths
    localparam int DATA_W      = 8;
    localparam int CFG_W       = 64;
    localparam int IDX_W       = 3;
    localparam int COUNT_W     = 3;
    localparam int LEN_W       = 4;
    localparam int LENS_W      = 16;
    localparam int SEEN_W      = 4;
    localparam int OUT_TDATA_W = 8;

    localparam logic [SEEN_W-1:0] SEEN_MAX = 4'hF;

    // Defaults for the top-level parameters
    localparam int MAX_PATTERNS_DEF    = 4;
    localparam int MAX_PATTERN_LEN_DEF = 8;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_PATTERN_COUNT   = 3'd0,
        REG_PATTERN_LENGTHS = 3'd1,
        REG_PATTERN_WORD_0  = 3'd2,
        REG_PATTERN_WORD_1  = 3'd3,
        REG_PATTERN_WORD_2  = 3'd4,
        REG_PATTERN_WORD_3  = 3'd5
    } cfg_reg_t;

    // Per-transfer control handed to the pattern units
    typedef struct packed {
        logic scan;   // accepted transfer carries a real byte
        logic clear;  // accepted transfer ends the value
    } aspm_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/aspm_cell.sv
// Window cell: holds one past byte, hands it to the next cell on a shift,
// and compares it against the byte each pattern expects at this position.
// Depends on aspm_pkg.
`default_nettype none

module aspm_cell #(
    parameter int NUM_PAT = aspm_pkg::MAX_PATTERNS_DEF
) (
    input  wire                          aclk,
    input  wire                          shift,
    input  wire  [aspm_pkg::DATA_W-1:0]  byte_in,
    input  logic [aspm_pkg::DATA_W-1:0]  exp_byte [NUM_PAT],
    output logic [aspm_pkg::DATA_W-1:0]  byte_out,
    output logic [NUM_PAT-1:0]           eq
);

    logic [aspm_pkg::DATA_W-1:0] byte_reg;

    // Advance the window on every real byte
    always_ff @(posedge aclk) begin
        if (shift) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

    // Compare the held byte against each pattern
    always_comb begin
        for (int i = 0; i < NUM_PAT; i++) begin
            eq[i] = (byte_reg == exp_byte[i]);
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/aspm_pat.sv
// Pattern unit: picks the expected byte for every window position, combines
// the cell compares into a hit and keeps the sticky found flag.
// Depends on aspm_pkg.
`default_nettype none

module aspm_pat #(
    parameter int MAX_PATTERN_LEN = aspm_pkg::MAX_PATTERN_LEN_DEF,
    parameter int WIN_W           = (MAX_PATTERN_LEN > 1) ? MAX_PATTERN_LEN - 1 : 1
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  aspm_pkg::aspm_ctrl_t         ctrl,
    input  wire                          active,
    input  wire  [aspm_pkg::CFG_W-1:0]   cfg_word,
    input  wire  [aspm_pkg::LEN_W-1:0]   len_raw,
    input  wire  [aspm_pkg::SEEN_W-1:0]  seen,
    input  wire  [aspm_pkg::DATA_W-1:0]  cur_byte,
    input  wire  [WIN_W-1:0]             win_eq,
    output logic [aspm_pkg::DATA_W-1:0]  exp_byte [MAX_PATTERN_LEN],
    output logic                         satisfied,
    output logic                         found
);

    localparam logic [aspm_pkg::LEN_W-1:0] LEN_CAP = aspm_pkg::LEN_W'(MAX_PATTERN_LEN);

    logic [aspm_pkg::LEN_W-1:0] len;
    logic [MAX_PATTERN_LEN-1:0] pos_eq;
    logic                       all_eq;
    logic                       long_enough;
    logic                       hit;
    logic                       found_reg;
    logic                       found_next;

    // Clamp the configured length
    assign len = (len_raw > LEN_CAP) ? LEN_CAP : len_raw;

    // Position j (0 = newest byte) must equal pattern byte len-1-j
    always_comb begin
        logic [2:0] idx;
        for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
            idx = 3'(len - aspm_pkg::LEN_W'(j) - 4'd1);
            if (aspm_pkg::LEN_W'(j) < len) begin
                exp_byte[j] = cfg_word[{idx, 3'b000} +: aspm_pkg::DATA_W];
            end else begin
                exp_byte[j] = '0;
            end
        end
    end

    // Gather the per-position compares: newest byte here, older ones from cells
    assign pos_eq[0] = (cur_byte == exp_byte[0]);
    generate
        if (MAX_PATTERN_LEN > 1) begin : g_win
            assign pos_eq[MAX_PATTERN_LEN-1:1] = win_eq[MAX_PATTERN_LEN-2:0];
        end else begin : g_nowin
            logic unused_win;
            assign unused_win = ^win_eq;
        end
    endgenerate

    always_comb begin
        all_eq = 1'b1;
        for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
            if (aspm_pkg::LEN_W'(j) < len && !pos_eq[j]) begin
                all_eq = 1'b0;
            end
        end
    end

    // Enough bytes of this value must be in the window
    assign long_enough = ({1'b0, seen} + 5'd1) >= {1'b0, len};
    assign hit = ctrl.scan && active && (len != '0) && long_enough && all_eq;

    // Sticky flag, dropped at the end of the value
    always_comb begin
        found_next = found_reg;
        if (ctrl.clear) begin
            found_next = 1'b0;
        end else if (hit) begin
            found_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
    end

    // The end item's own byte counts toward the result
    assign satisfied = !active || (len == '0) || found_reg || hit;
    assign found     = found_reg;

endmodule

`default_nettype wire

// File: rtl/core/all_substrings_present_matcher_top.sv
// All-substrings-present matcher: one byte per transfer, one result per value.
// The end transfer registers its result in the head, or the skid entry if the head is held.
// Throughput: one input transfer per cycle while the skid entry is empty, set by the window
// cell row that compares every position against every pattern in parallel.
// Reset (aresetn low, synchronous) clears the registers, count, flags and result buffer.
// Depends on aspm_pkg, aspm_cell and aspm_pat.
`default_nettype none

module all_substrings_present_matcher_top #(
    parameter int MAX_PATTERNS    = aspm_pkg::MAX_PATTERNS_DEF,
    parameter int MAX_PATTERN_LEN = aspm_pkg::MAX_PATTERN_LEN_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // Configuration write port
    input  wire                              cfg_wr_en,
    input  wire  [aspm_pkg::IDX_W-1:0]       cfg_wr_index,
    input  wire  [aspm_pkg::CFG_W-1:0]       cfg_wr_data,
    // Input stream
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [aspm_pkg::DATA_W-1:0]      s_tdata,  // [7:0] data_byte
    input  wire                              s_tuser,  // [0] byte_present
    input  wire                              s_tlast,  // value_end
    // Result stream
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [aspm_pkg::OUT_TDATA_W-1:0] m_tdata   // [0] all_found, [7:1] zero
);

    localparam int WIN_W = (MAX_PATTERN_LEN > 1) ? MAX_PATTERN_LEN - 1 : 1;
    localparam logic [aspm_pkg::COUNT_W-1:0] COUNT_CAP = aspm_pkg::COUNT_W'(MAX_PATTERNS);

    // Configuration registers
    logic [aspm_pkg::COUNT_W-1:0] count_reg;
    logic [aspm_pkg::LENS_W-1:0]  lengths_reg;
    logic [aspm_pkg::CFG_W-1:0]   word_reg [MAX_PATTERNS];

    logic [aspm_pkg::COUNT_W-1:0] count_eff;
    logic [MAX_PATTERNS-1:0]      active;

    // Per-value state and datapath
    logic                         accept;
    aspm_pkg::aspm_ctrl_t         ctrl;
    logic [aspm_pkg::SEEN_W-1:0]  seen_reg;
    logic [aspm_pkg::SEEN_W-1:0]  seen_next;
    logic [MAX_PATTERNS-1:0]      satisfied;
    logic [MAX_PATTERNS-1:0]      found;
    logic                         result;

    logic [aspm_pkg::DATA_W-1:0]  pat_exp [MAX_PATTERNS][MAX_PATTERN_LEN];
    wire  [WIN_W-1:0]             win_eq  [MAX_PATTERNS];

    // Result buffer: head and one skid entry
    logic out_valid_reg, out_valid_next;
    logic out_data_reg,  out_data_next;
    logic skid_valid_reg, skid_valid_next;
    logic skid_data_reg,  skid_data_next;
    logic pop;

    // Count and length writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            lengths_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                aspm_pkg::REG_PATTERN_COUNT:
                    count_reg <= cfg_wr_data[aspm_pkg::COUNT_W-1:0];
                aspm_pkg::REG_PATTERN_LENGTHS:
                    lengths_reg <= cfg_wr_data[aspm_pkg::LENS_W-1:0];
                default: ;
            endcase
        end
    end

    // Pattern word writes, one register per supported pattern
    generate
        for (genvar i = 0; i < MAX_PATTERNS; i++) begin : g_word
            localparam logic [aspm_pkg::IDX_W-1:0] WIDX =
                aspm_pkg::IDX_W'(aspm_pkg::REG_PATTERN_WORD_0 + i);
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    word_reg[i] <= '0;
                end else if (cfg_wr_en && cfg_wr_index == WIDX) begin
                    word_reg[i] <= cfg_wr_data;
                end
            end
        end
    endgenerate

    // Clamp the pattern count and mark the patterns in use
    assign count_eff = (count_reg > COUNT_CAP) ? COUNT_CAP : count_reg;
    always_comb begin
        for (int i = 0; i < MAX_PATTERNS; i++) begin
            active[i] = aspm_pkg::COUNT_W'(i) < count_eff;
        end
    end

    // Input handshake
    assign s_tready   = !skid_valid_reg;
    assign accept     = s_tvalid && s_tready;
    assign ctrl.scan  = accept && s_tuser;
    assign ctrl.clear = accept && s_tlast;

    // Saturating byte count, dropped at the end of the value
    always_comb begin
        seen_next = seen_reg;
        if (ctrl.clear) begin
            seen_next = '0;
        end else if (ctrl.scan && seen_reg != aspm_pkg::SEEN_MAX) begin
            seen_next = seen_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
        end else begin
            seen_reg <= seen_next;
        end
    end

    // Row of window cells; cell j holds the byte j+1 present bytes back
    generate
        if (MAX_PATTERN_LEN > 1) begin : g_cells
            logic [aspm_pkg::DATA_W-1:0]  cell_in  [MAX_PATTERN_LEN-1];
            logic [aspm_pkg::DATA_W-1:0]  cell_out [MAX_PATTERN_LEN-1];
            logic [MAX_PATTERNS-1:0]      cell_eq  [MAX_PATTERN_LEN-1];
            logic [aspm_pkg::DATA_W-1:0]  cell_exp [MAX_PATTERN_LEN-1][MAX_PATTERNS];

            for (genvar j = 0; j < MAX_PATTERN_LEN - 1; j++) begin : g_cell
                if (j == 0) begin : g_head
                    assign cell_in[j] = s_tdata;
                end else begin : g_link
                    assign cell_in[j] = cell_out[j-1];
                end

                for (genvar i = 0; i < MAX_PATTERNS; i++) begin : g_route
                    assign cell_exp[j][i] = pat_exp[i][j+1];
                    assign win_eq[i][j]   = cell_eq[j][i];
                end

                aspm_cell #(
                    .NUM_PAT (MAX_PATTERNS)
                ) u_cell (
                    .aclk     (aclk),
                    .shift    (ctrl.scan),
                    .byte_in  (cell_in[j]),
                    .exp_byte (cell_exp[j]),
                    .byte_out (cell_out[j]),
                    .eq       (cell_eq[j])
                );
            end
        end else begin : g_nocells
            for (genvar i = 0; i < MAX_PATTERNS; i++) begin : g_tie
                assign win_eq[i] = '0;
            end
        end
    endgenerate

    // One pattern unit per supported pattern
    generate
        for (genvar i = 0; i < MAX_PATTERNS; i++) begin : g_pat
            aspm_pat #(
                .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
                .WIN_W           (WIN_W)
            ) u_pat (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .active    (active[i]),
                .cfg_word  (word_reg[i]),
                .len_raw   (lengths_reg[aspm_pkg::LEN_W*i +: aspm_pkg::LEN_W]),
                .seen      (seen_reg),
                .cur_byte  (s_tdata),
                .win_eq    (win_eq[i]),
                .exp_byte  (pat_exp[i]),
                .satisfied (satisfied[i]),
                .found     (found[i])
            );
        end
    endgenerate

    assign result = &satisfied;

    // Result buffer: pop the head, then push the new result behind it
    assign pop = out_valid_reg && m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop) begin
            out_valid_next  = skid_valid_reg;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        if (ctrl.clear) begin
            if (!out_valid_next) begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(aspm_pkg::OUT_TDATA_W-1){1'b0}}, out_data_reg};

    // Skid entry is only ever filled behind a valid head
    a_skid_behind_head: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty head");

    // End of value leaves a clean count and no found flags
    a_clear_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (seen_reg == '0 && found == '0))
        else $error("per-value state not cleared after end transfer");

    // A mid-value byte advances the count until it saturates
    a_seen_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser && !s_tlast && seen_reg != aspm_pkg::SEEN_MAX)
        |=> (seen_reg == $past(seen_reg) + 4'd1))
        else $error("byte count did not advance");

endmodule

`default_nettype wire
